// File: hdl/sbx_pkg.sv
// sbx_pkg: shared types and constants for the segment/box crossing test.
// No dependencies; imported by sbx_face and segment_box_crossing_test_core.
package sbx_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_Z_LOW  = 3'd4,
    REG_Z_HIGH = 3'd5
  } cfg_reg_e;

  localparam int unsigned NumBounds = 6;
  localparam int unsigned NumFaces  = 6;

  // Load enables of the face lane stages
  typedef struct packed {
    logic l2;
    logic l3;
    logic l4;
    logic l5;
  } lane_en_t;

endpackage

// File: hdl/segment_box_crossing_test_core.sv
// segment_box_crossing_test_core: top level, bound registers, stage 1,
// pipeline control and result register. Depends on sbx_pkg and sbx_face.
//
//  channel | handshake                   | word
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o     | start_x/y/z_i, end_x/y/z_i
//  out     | out_valid_o / out_stall_i   | blocked_o
//  cfg     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Six register stages; while nothing stalls a word is accepted every
// cycle and its result leaves the stage 6 register. Each stage has a valid bit
// and loads when it is empty or the stage after it moves, so bubbles close
// up under a stalled output. Reset clears the valid bits and the box bounds.
// cfg_ready_o is always high.
module segment_box_crossing_test_core #(
  parameter int unsigned CoordBits = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [CoordBits-1:0]                 start_x_i,
  input  logic [CoordBits-1:0]                 start_y_i,
  input  logic [CoordBits-1:0]                 start_z_i,
  input  logic [CoordBits-1:0]                 end_x_i,
  input  logic [CoordBits-1:0]                 end_y_i,
  input  logic [CoordBits-1:0]                 end_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 blocked_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sbx_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [CoordBits-1:0]                 cfg_data_i
);
  import sbx_pkg::*;

  localparam int unsigned CW = CoordBits + 1;

  // Box bound registers
  logic [CoordBits-1:0] bnd_q [NumBounds];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NumBounds; n++) begin
        bnd_q[n] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i <= REG_Z_HIGH)) begin
      bnd_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Pipeline control: stage k loads when empty or when stage k+1 loads
  logic [6:1] v_q, v_d;
  logic [6:1] en;

  always_comb begin
    en[6] = !v_q[6] || !out_stall_i;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[1]) begin
      v_d[1] = in_valid_i;
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[6];

  // Stage 1: differences, face origins, edges and the inside test
  function automatic logic signed [CW-1:0] sdiff(input logic [CoordBits-1:0] p,
                                                 input logic [CoordBits-1:0] q);
    return $signed({1'b0, p}) - $signed({1'b0, q});
  endfunction

  logic signed [CW-1:0] dx_q, dy_q, dz_q;
  logic signed [CW-1:0] rxl_q, rxh_q, ryl_q, ryh_q, rzl_q, rzh_q;
  logic signed [CW-1:0] wx_q, wy_q, wz_q;
  logic                 inside_d;
  logic [5:1]           inside_q;

  assign inside_d = (bnd_q[REG_X_LOW] <= end_x_i) && (end_x_i <= bnd_q[REG_X_HIGH]) &&
                    (bnd_q[REG_Y_LOW] <= end_y_i) && (end_y_i <= bnd_q[REG_Y_HIGH]) &&
                    (bnd_q[REG_Z_LOW] <= end_z_i) && (end_z_i <= bnd_q[REG_Z_HIGH]);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dx_q        <= sdiff(end_x_i, start_x_i);
      dy_q        <= sdiff(end_y_i, start_y_i);
      dz_q        <= sdiff(end_z_i, start_z_i);
      rxl_q       <= sdiff(bnd_q[REG_X_LOW], start_x_i);
      rxh_q       <= sdiff(bnd_q[REG_X_HIGH], start_x_i);
      ryl_q       <= sdiff(bnd_q[REG_Y_LOW], start_y_i);
      ryh_q       <= sdiff(bnd_q[REG_Y_HIGH], start_y_i);
      rzl_q       <= sdiff(bnd_q[REG_Z_LOW], start_z_i);
      rzh_q       <= sdiff(bnd_q[REG_Z_HIGH], start_z_i);
      wx_q        <= sdiff(bnd_q[REG_X_HIGH], bnd_q[REG_X_LOW]);
      wy_q        <= sdiff(bnd_q[REG_Y_HIGH], bnd_q[REG_Y_LOW]);
      wz_q        <= sdiff(bnd_q[REG_Z_HIGH], bnd_q[REG_Z_LOW]);
      inside_q[1] <= inside_d;
    end
  end

  // Inside flag rides alongside the face lanes
  always_ff @(posedge clk_i) begin
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        inside_q[k] <= inside_q[k-1];
      end
    end
  end

  // Face lanes, stages 2 to 5: (i, j, k) = edge axes and normal axis
  lane_en_t            lane_en;
  logic [NumFaces-1:0] hit;

  assign lane_en = '{l2: en[2], l3: en[3], l4: en[4], l5: en[5]};

  // y = y_low face
  sbx_face #(.CoordBits(CoordBits), .Skew(1'b0)) u_face_ylo (
    .clk_i, .en_i(lane_en),
    .di_i(dx_q), .dj_i(dz_q), .dk_i(dy_q),
    .ri_i(rxl_q), .rj_i(rzl_q), .rk_i(ryl_q),
    .a_i(wx_q), .b_i(wz_q), .hit_o(hit[0])
  );

  // x = x_high face
  sbx_face #(.CoordBits(CoordBits), .Skew(1'b0)) u_face_xhi (
    .clk_i, .en_i(lane_en),
    .di_i(dy_q), .dj_i(dz_q), .dk_i(dx_q),
    .ri_i(ryl_q), .rj_i(rzl_q), .rk_i(rxh_q),
    .a_i(wy_q), .b_i(wz_q), .hit_o(hit[1])
  );

  // y = y_high face, other edge along the x/z diagonal
  sbx_face #(.CoordBits(CoordBits), .Skew(1'b1)) u_face_yhi (
    .clk_i, .en_i(lane_en),
    .di_i(dx_q), .dj_i(dz_q), .dk_i(dy_q),
    .ri_i(rxl_q), .rj_i(rzl_q), .rk_i(ryh_q),
    .a_i(wx_q), .b_i(wz_q), .hit_o(hit[2])
  );

  // x = x_low face
  sbx_face #(.CoordBits(CoordBits), .Skew(1'b0)) u_face_xlo (
    .clk_i, .en_i(lane_en),
    .di_i(dy_q), .dj_i(dz_q), .dk_i(dx_q),
    .ri_i(ryl_q), .rj_i(rzl_q), .rk_i(rxl_q),
    .a_i(wy_q), .b_i(wz_q), .hit_o(hit[3])
  );

  // z = z_low face
  sbx_face #(.CoordBits(CoordBits), .Skew(1'b0)) u_face_zlo (
    .clk_i, .en_i(lane_en),
    .di_i(dx_q), .dj_i(dy_q), .dk_i(dz_q),
    .ri_i(rxl_q), .rj_i(ryl_q), .rk_i(rzl_q),
    .a_i(wx_q), .b_i(wy_q), .hit_o(hit[4])
  );

  // z = z_high face
  sbx_face #(.CoordBits(CoordBits), .Skew(1'b0)) u_face_zhi (
    .clk_i, .en_i(lane_en),
    .di_i(dx_q), .dj_i(dy_q), .dk_i(dz_q),
    .ri_i(rxl_q), .rj_i(ryl_q), .rk_i(rzh_q),
    .a_i(wx_q), .b_i(wy_q), .hit_o(hit[5])
  );

  // Stage 6: result register
  logic blocked_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      blocked_q <= inside_q[5] || (|hit);
    end
  end

  assign blocked_o = blocked_q;

  // An empty pipeline never pushes back on the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0) |-> !in_stall_o)
    else $error("input stalled with an empty pipeline");

  // With a free output, an accepted word comes out of the stage 6 result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not arrive at the output in time");

  // Writes past the last bound register leave the box unchanged
  a_cfg_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i > REG_Z_HIGH)) |=>
      ($stable(bnd_q[0]) && $stable(bnd_q[1]) && $stable(bnd_q[2]) &&
       $stable(bnd_q[3]) && $stable(bnd_q[4]) && $stable(bnd_q[5])))
    else $error("out-of-range register write changed a bound");

endmodule

// File: hdl/sbx_face.sv
// sbx_face: one box face tested against the segment, stages 2 to 5.
// Depends on sbx_pkg (lane_en_t). Skew selects the slanted face whose
// other edge runs along the diagonal of the i edge and the j axis.
module sbx_face #(
  parameter int unsigned CoordBits = 10,
  parameter bit          Skew      = 1'b0
) (
  input  logic                      clk_i,
  input  sbx_pkg::lane_en_t         en_i,
  input  logic signed [CoordBits:0] di_i,
  input  logic signed [CoordBits:0] dj_i,
  input  logic signed [CoordBits:0] dk_i,
  input  logic signed [CoordBits:0] ri_i,
  input  logic signed [CoordBits:0] rj_i,
  input  logic signed [CoordBits:0] rk_i,
  input  logic signed [CoordBits:0] a_i,
  input  logic signed [CoordBits:0] b_i,
  output logic                      hit_o
);
  import sbx_pkg::*;

  localparam int unsigned CW = CoordBits + 1;     // differences, edges
  localparam int unsigned PW = 2 * CoordBits + 2; // single products
  localparam int unsigned MW = 2 * CoordBits + 3; // cross terms
  localparam int unsigned NW = 3 * CoordBits + 5; // widest compare

  // 0 <= n/dn <= 1 without division, dn known nonzero where it matters
  function automatic logic in_unit(input logic signed [NW-1:0] n,
                                   input logic signed [NW-1:0] dn);
    logic r;
    if (dn > 0) begin
      r = (n >= 0) && (n <= dn);
    end else begin
      r = (n <= 0) && (n >= dn);
    end
    return r;
  endfunction

  // Stage 2: products of the segment and origin terms
  logic signed [PW-1:0] pik_q, pki_q, pjk_q, pkj_q, bd2_q;
  logic signed [PW-1:0] pik_d, pki_d, pjk_d, pkj_d, bd2_d;
  logic                 t1_2_q, nz2_q;

  assign pik_d = di_i * rk_i;
  assign pki_d = dk_i * ri_i;
  assign pjk_d = dj_i * rk_i;
  assign pkj_d = dk_i * rj_i;
  assign bd2_d = b_i * dk_i;

  always_ff @(posedge clk_i) begin
    if (en_i.l2) begin
      pik_q  <= pik_d;
      pki_q  <= pki_d;
      pjk_q  <= pjk_d;
      pkj_q  <= pkj_d;
      bd2_q  <= bd2_d;
      t1_2_q <= in_unit(NW'(rk_i), NW'(dk_i));
      nz2_q  <= (a_i != '0) && (b_i != '0) && (dk_i != '0);
    end
  end

  // Stage 3: cross terms
  logic signed [MW-1:0] m2_q, m3_q;
  logic signed [PW-1:0] bd3_q;
  logic                 pre3_q;

  always_ff @(posedge clk_i) begin
    if (en_i.l3) begin
      m2_q   <= MW'(pik_q) - MW'(pki_q);
      m3_q   <= MW'(pjk_q) - MW'(pkj_q);
      bd3_q  <= bd2_q;
      pre3_q <= t1_2_q && nz2_q;
    end
  end

  // Stage 4: third parameter; the i-edge parameter per face kind
  logic t3_q, pre4_q, t2_fin;

  always_ff @(posedge clk_i) begin
    if (en_i.l4) begin
      t3_q   <= in_unit(NW'(m3_q), NW'(bd3_q));
      pre4_q <= pre3_q;
    end
  end

  if (Skew) begin : g_skew
    // s = m2/(a dk) - m3/(b dk), tested over the common denominator a b dk
    localparam int unsigned AW = 3 * CoordBits + 3;
    localparam int unsigned BW = 3 * CoordBits + 4;
    logic signed [PW-1:0] ab2_q;
    logic signed [CW-1:0] a2_q, b2_q, a3_q, b3_q, dk2_q;
    logic signed [AW-1:0] abd3_q, abd4_q;
    logic signed [BW-1:0] bm4_q, am4_q;
    logic signed [NW-1:0] num;

    always_ff @(posedge clk_i) begin
      if (en_i.l2) begin
        ab2_q <= a_i * b_i;
        a2_q  <= a_i;
        b2_q  <= b_i;
        dk2_q <= dk_i;
      end
      if (en_i.l3) begin
        abd3_q <= AW'(ab2_q) * AW'(dk2_q);
        a3_q   <= a2_q;
        b3_q   <= b2_q;
      end
      if (en_i.l4) begin
        bm4_q  <= BW'(b3_q) * BW'(m2_q);
        am4_q  <= BW'(a3_q) * BW'(m3_q);
        abd4_q <= abd3_q;
      end
    end

    assign num    = NW'(bm4_q) - NW'(am4_q);
    assign t2_fin = in_unit(num, NW'(abd4_q));
  end else begin : g_flat
    logic signed [PW-1:0] ad2_q, ad3_q;
    logic                 t2_q;

    always_ff @(posedge clk_i) begin
      if (en_i.l2) begin
        ad2_q <= a_i * dk_i;
      end
      if (en_i.l3) begin
        ad3_q <= ad2_q;
      end
      if (en_i.l4) begin
        t2_q <= in_unit(NW'(m2_q), NW'(ad3_q));
      end
    end

    assign t2_fin = t2_q;
  end

  // Stage 5: face hit
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en_i.l5) begin
      hit_q <= pre4_q && t3_q && t2_fin;
    end
  end

  assign hit_o = hit_q;

endmodule
